### design/filename_utf8_checker_assert.svh
// Assertion macros used by the filename checker top level.
`ifndef FILENAME_UTF8_CHECKER_ASSERT_SVH
`define FILENAME_UTF8_CHECKER_ASSERT_SVH

// Condition that must hold on every clock edge outside reset.
`define FUC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define FUC_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### design/fuc_pkg.sv
// Types and constants for the filename UTF-8 checker.
`default_nettype none

package fuc_pkg;

  // Byte codes used by the name checks; slash, backslash, percent and DEL are never allowed in a name
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  // Code point limits
  localparam logic [20:0] CP_MIN2     = 21'h00080;
  localparam logic [20:0] CP_MIN3     = 21'h00800;
  localparam logic [20:0] CP_MIN4     = 21'h10000;
  localparam logic [20:0] CP_SURR_LO  = 21'h0d800;
  localparam logic [20:0] CP_SURR_HI  = 21'h0dfff;
  localparam logic [20:0] CP_MAX      = 21'h10ffff;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] code_point;
    logic        bad_seen;
    logic        only_dots;
  } fuc_state_t;

  localparam fuc_state_t FUC_STATE_RST = '{
    cont_left:  2'd0,
    seq_len:    3'd0,
    code_point: 21'd0,
    bad_seen:   1'b0,
    only_dots:  1'b1
  };

endpackage

`default_nettype wire

### design/fuc_step.sv
// Next decoder state for one non-terminator name byte.
`default_nettype none

module fuc_step
  import fuc_pkg::*;
(
  input  wire logic [7:0] name_byte,
  input  fuc_state_t      cur,
  output fuc_state_t      nxt
);

  logic [20:0] cp_acc;
  logic [1:0]  cl_dec;
  logic        do_lead;

  always_comb begin
    nxt     = cur;
    cp_acc  = {cur.code_point[14:0], name_byte[5:0]};
    cl_dec  = cur.cont_left - 2'd1;
    do_lead = 1'b1;

    if (name_byte != CH_DOT) nxt.only_dots = 1'b0;
    if (name_byte < CH_SPACE || name_byte == CH_DEL || name_byte == CH_SLASH ||
        name_byte == CH_BSLASH || name_byte == CH_PCT) begin
      nxt.bad_seen = 1'b1;
    end

    if (cur.cont_left != 2'd0) begin
      if (name_byte[7:6] == 2'b10) begin
        do_lead        = 1'b0;
        nxt.code_point = cp_acc;
        nxt.cont_left  = cl_dec;
        if (cl_dec == 2'd0) begin
          // sequence complete: overlong, surrogate and range checks
          if ((cur.seq_len == 3'd2 && cp_acc < CP_MIN2) ||
              (cur.seq_len == 3'd3 && cp_acc < CP_MIN3) ||
              (cur.seq_len == 3'd4 && cp_acc < CP_MIN4) ||
              (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
              cp_acc > CP_MAX) begin
            nxt.bad_seen = 1'b1;
          end
          nxt.seq_len    = 3'd0;
          nxt.code_point = '0;
        end
      end else begin
        // broken sequence: drop it and treat this byte as a new lead
        nxt.bad_seen   = 1'b1;
        nxt.cont_left  = 2'd0;
        nxt.seq_len    = 3'd0;
        nxt.code_point = '0;
      end
    end

    if (do_lead && name_byte[7]) begin
      priority casez (name_byte)
        8'b110?_???? : begin
          nxt.code_point = {16'd0, name_byte[4:0]};
          if (name_byte[4:1] == 4'd0) begin
            nxt.bad_seen = 1'b1;
          end else begin
            nxt.cont_left = 2'd1;
            nxt.seq_len   = 3'd2;
          end
        end
        8'b1110_???? : begin
          nxt.code_point = {17'd0, name_byte[3:0]};
          nxt.cont_left  = 2'd2;
          nxt.seq_len    = 3'd3;
        end
        8'b1111_0??? : begin
          nxt.code_point = {18'd0, name_byte[2:0]};
          if (name_byte[2:0] > 3'd4) begin
            nxt.bad_seen = 1'b1;
          end else begin
            nxt.cont_left = 2'd3;
            nxt.seq_len   = 3'd4;
          end
        end
        default: nxt.bad_seen = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/filename_utf8_checker.sv
// Top level of the filename checker with UTF-8 validation.
// The verdict is registered in the output slot, or in the skid when that is held.
// Throughput: one byte per cycle unless the skid is full; one-pass state update.
// A two-entry output (register plus skid) keeps input flowing while a verdict waits.
// Reset: synchronous rst clears decoder state, byte count and output valids.
`default_nettype none
`include "filename_utf8_checker_assert.svh"

module filename_utf8_checker
  import fuc_pkg::*;
#(
  parameter int MAX_NAME_BYTES = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] name_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [0] name_ok, [9:1] name_length, [15:10] zero
);

  localparam int CNT_W = $clog2(MAX_NAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_BYTES);

  fuc_state_t       st;
  fuc_state_t       st_step;
  logic [CNT_W-1:0] byte_count;

  logic             in_fire;
  logic             res_fire;
  logic             res_ok;
  logic [8:0]       res_len;
  logic [CNT_W+8:0] cnt_ext;

  logic             out_valid;
  logic             out_ok;
  logic [8:0]       out_len;
  logic             skid_valid;
  logic             skid_ok;
  logic [8:0]       skid_len;

  fuc_step u_step (
    .name_byte (s_tdata),
    .cur       (st),
    .nxt       (st_step)
  );

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign res_fire = in_fire && (s_tdata == 8'd0);

  assign cnt_ext = {9'd0, byte_count};
  assign res_len = cnt_ext[8:0];
  assign res_ok  = !st.bad_seen && st.cont_left == 2'd0 && byte_count != '0 &&
                   byte_count <= CNT_MAX &&
                   !(st.only_dots && (byte_count == CNT_W'(1) || byte_count == CNT_W'(2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= FUC_STATE_RST;
      byte_count <= '0;
    end else if (in_fire) begin
      if (s_tdata == 8'd0) begin
        st         <= FUC_STATE_RST;
        byte_count <= '0;
      end else begin
        st <= st_step;
        if (byte_count <= CNT_MAX) byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  // output slot plus skid; input stalls only when both hold a verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_ok  <= skid_ok;
        out_len <= skid_len;
      end else if (res_fire) begin
        out_ok  <= res_ok;
        out_len <= res_len;
      end
    end else if (res_fire) begin
      skid_ok  <= res_ok;
      skid_len <= res_len;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_len, out_ok};

  `FUC_ASSERT(a_skid_behind_out, !skid_valid || out_valid, "skid full, output empty")
  `FUC_IMPLY(a_term_gives_verdict, res_fire, m_tvalid, "terminator beat gave no verdict")
  `FUC_ASSERT(a_count_sat, byte_count <= CNT_MAX + CNT_W'(1), "byte count past saturation")
  `FUC_ASSERT(a_seq_track, (st.cont_left == 2'd0) == (st.seq_len == 3'd0), "seq_len skew")

endmodule

`default_nettype wire
